>>> rtl/timed_event_queue_assert.svh
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define TEQ_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define TEQ_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/teq_pkg.sv
package teq_pkg;

    localparam logic [1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [1:0] KIND_ADVANCE  = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    localparam int MAX_RESULTS = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCHED_RD,
        ST_SCHED_CMP,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_DISP_RD,
        ST_DISP_CHK,
        ST_DISP_OUT
    } state_t;

    // Payload stored for one slot.
    typedef struct packed {
        logic [63:0] due;
        logic [31:0] id;
        logic [31:0] parent;
        logic [7:0]  etype;
        logic [31:0] source;
        logic [31:0] param;
    } slot_data_t;

endpackage

>>> rtl/teq_mem.sv
// Slot payload and link memories with registered reads.
module teq_mem #(
    parameter int SLOTS = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                data_we,
    input  logic [AW-1:0]       data_waddr,
    input  teq_pkg::slot_data_t data_wdata,
    input  logic [AW-1:0]       data_raddr,
    output teq_pkg::slot_data_t data_rdata,
    input  logic                link_we,
    input  logic [AW-1:0]       link_waddr,
    input  logic [AW-1:0]       link_wdata,
    input  logic [AW-1:0]       link_raddr,
    output logic [AW-1:0]       link_rdata
);
    teq_pkg::slot_data_t data_mem [SLOTS];
    logic [AW-1:0]       link_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        data_rdata <= data_mem[data_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
    end
endmodule

>>> rtl/teq_ctrl.sv
// Sequencer for insert walk, dispatch and list bookkeeping.
module teq_ctrl #(
    parameter int SLOTS = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_kind,
    input  logic [31:0]         in_delay,
    input  logic [31:0]         in_advance,
    input  teq_pkg::slot_data_t in_payload,
    output logic                o_valid,
    input  logic                o_ready,
    output teq_pkg::slot_data_t o_data,
    output logic                o_last,
    output logic                data_we,
    output logic [AW-1:0]       data_waddr,
    output teq_pkg::slot_data_t data_wdata,
    output logic [AW-1:0]       data_raddr,
    input  teq_pkg::slot_data_t data_rdata,
    output logic                link_we,
    output logic [AW-1:0]       link_waddr,
    output logic [AW-1:0]       link_wdata,
    output logic [AW-1:0]       link_raddr,
    input  logic [AW-1:0]       link_rdata
);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(teq_pkg::MAX_RESULTS + 1);

    teq_pkg::state_t state_reg, state_next;
    logic [63:0]     time_reg, time_next;
    logic [31:0]     id_reg, id_next;
    logic [AW-1:0]   qhead_reg, qhead_next, fhead_reg, fhead_next;
    logic [CW-1:0]   qcnt_reg, qcnt_next, fcnt_reg, fcnt_next;
    logic [AW-1:0]   init_reg, init_next;
    logic [AW-1:0]   new_reg, new_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [63:0]     due_reg, due_next;
    logic [NW-1:0]   n_reg, n_next;
    logic            ov_reg, ov_next;
    logic            ofin_reg, ofin_next;
    logic            ol_reg, ol_next;
    teq_pkg::slot_data_t od_reg, od_next;
    logic            o_take;
    logic            pend_reg;

    // A held event is shown only once it is known whether it is the last one.
    assign o_valid  = ov_reg && ofin_reg;
    assign o_take   = o_valid && o_ready;
    assign in_ready = (state_reg == teq_pkg::ST_IDLE);
    assign o_data   = od_reg;
    assign o_last   = ol_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            teq_pkg::ST_INIT:
            begin
                if (init_reg == LAST_SLOT)
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_kind == teq_pkg::KIND_SCHEDULE && fcnt_reg != '0)
                    begin
                        state_next = teq_pkg::ST_SCHED_RD;
                    end
                    else if (in_kind == teq_pkg::KIND_DISPATCH)
                    begin
                        state_next = teq_pkg::ST_DISP_RD;
                    end
                end
            end
            teq_pkg::ST_SCHED_RD:  state_next = teq_pkg::ST_SCHED_CMP;
            teq_pkg::ST_SCHED_CMP:
            begin
                if (qcnt_reg == '0 || due_reg < data_rdata.due || qcnt_reg == CW'(1))
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = teq_pkg::ST_WALK_RD;
                end
            end
            teq_pkg::ST_WALK_RD:   state_next = teq_pkg::ST_WALK_CMP;
            teq_pkg::ST_WALK_CMP:
            begin
                if (data_rdata.due > due_reg || rem_reg == CW'(1))
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = teq_pkg::ST_WALK_RD;
                end
            end
            teq_pkg::ST_DISP_RD:
            begin
                if (qcnt_reg == '0 || n_reg == NW'(teq_pkg::MAX_RESULTS))
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = teq_pkg::ST_DISP_CHK;
                end
            end
            teq_pkg::ST_DISP_CHK:
            begin
                if (data_rdata.due > time_reg)
                begin
                    state_next = teq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = teq_pkg::ST_DISP_OUT;
                end
            end
            teq_pkg::ST_DISP_OUT:
            begin
                if (!ov_reg || o_take)
                begin
                    state_next = teq_pkg::ST_DISP_RD;
                end
            end
            default: state_next = teq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        time_next  = time_reg;
        id_next    = id_reg;
        qhead_next = qhead_reg;
        fhead_next = fhead_reg;
        qcnt_next  = qcnt_reg;
        fcnt_next  = fcnt_reg;
        init_next  = init_reg;
        new_next   = new_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        due_next   = due_reg;
        n_next     = n_reg;
        ov_next    = ov_reg && !o_take;
        ofin_next  = ofin_reg;
        ol_next    = ol_reg;
        od_next    = od_reg;
        data_we    = 1'b0;
        data_waddr = new_reg;
        data_wdata = in_payload;
        data_raddr = qhead_reg;
        link_we    = 1'b0;
        link_waddr = init_reg;
        link_wdata = init_reg + AW'(1);
        link_raddr = fhead_reg;
        case (state_reg)
            teq_pkg::ST_INIT:
            begin
                link_we = 1'b1;
                if (init_reg == LAST_SLOT)
                begin
                    link_wdata = '0;
                end
                init_next = init_reg + AW'(1);
            end
            teq_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_kind)
                        teq_pkg::KIND_SCHEDULE:
                        begin
                            if (fcnt_reg != '0)
                            begin
                                // Slot payload written now; free link read below.
                                data_we    = 1'b1;
                                data_waddr = fhead_reg;
                                data_wdata = in_payload;
                                data_wdata.due = time_reg + {32'd0, in_delay};
                                data_wdata.id  = id_reg;
                                due_next   = data_wdata.due;
                                new_next   = fhead_reg;
                                id_next    = id_reg + 32'd1;
                                fcnt_next  = fcnt_reg - CW'(1);
                            end
                        end
                        teq_pkg::KIND_ADVANCE:
                            time_next = time_reg + {32'd0, in_advance};
                        teq_pkg::KIND_DISPATCH:
                            n_next = '0;
                        default: ;
                    endcase
                end
            end
            teq_pkg::ST_SCHED_RD:
            begin
                // Free-list successor of the taken slot becomes the free head.
                fhead_next = link_rdata;
                data_raddr = qhead_reg;
                link_raddr = qhead_reg;
            end
            teq_pkg::ST_SCHED_CMP:
            begin
                if (qcnt_reg == '0 || due_reg < data_rdata.due)
                begin
                    link_we    = 1'b1;
                    link_waddr = new_reg;
                    link_wdata = qhead_reg;
                    qhead_next = new_reg;
                    qcnt_next  = qcnt_reg + CW'(1);
                end
                else if (qcnt_reg == CW'(1))
                begin
                    link_we    = 1'b1;
                    link_waddr = qhead_reg;
                    link_wdata = new_reg;
                    qcnt_next  = qcnt_reg + CW'(1);
                end
                else
                begin
                    cur_next   = qhead_reg;
                    rem_next   = qcnt_reg - CW'(1);
                    link_raddr = qhead_reg;
                end
            end
            teq_pkg::ST_WALK_RD:
            begin
                // link_rdata holds link of cur; read that successor's data.
                // The new slot points at that successor in case the walk stops here.
                data_raddr = link_rdata;
                link_raddr = cur_reg;
                link_we    = 1'b1;
                link_waddr = new_reg;
                link_wdata = link_rdata;
            end
            teq_pkg::ST_WALK_CMP:
            begin
                if (data_rdata.due > due_reg || rem_reg == CW'(1))
                begin
                    link_we    = 1'b1;
                    link_wdata = new_reg;
                    if (data_rdata.due > due_reg)
                    begin
                        link_waddr = cur_reg;
                    end
                    else
                    begin
                        link_waddr = link_rdata;
                    end
                    qcnt_next = qcnt_reg + CW'(1);
                end
                else
                begin
                    cur_next   = link_rdata;
                    rem_next   = rem_reg - CW'(1);
                    link_raddr = link_rdata;
                end
            end
            teq_pkg::ST_DISP_RD:
            begin
                data_raddr = qhead_reg;
                link_raddr = qhead_reg;
                if (qcnt_reg == '0 || n_reg == NW'(teq_pkg::MAX_RESULTS))
                begin
                    if (ov_reg && !ofin_reg)
                    begin
                        ofin_next = 1'b1;
                        ol_next   = 1'b1;
                    end
                end
            end
            teq_pkg::ST_DISP_CHK:
            begin
                cur_next = link_rdata;
                if (data_rdata.due > time_reg)
                begin
                    if (ov_reg && !ofin_reg)
                    begin
                        ofin_next = 1'b1;
                        ol_next   = 1'b1;
                    end
                end
                else
                begin
                    // Another event is due, so the held one is not the last.
                    ofin_next = 1'b1;
                end
            end
            teq_pkg::ST_DISP_OUT:
            begin
                if (!ov_reg || o_take)
                begin
                    ov_next    = 1'b1;
                    ofin_next  = 1'b0;
                    ol_next    = 1'b0;
                    od_next    = data_rdata;
                    link_we    = 1'b1;
                    link_waddr = qhead_reg;
                    link_wdata = fhead_reg;
                    fhead_next = qhead_reg;
                    qhead_next = cur_reg;
                    qcnt_next  = qcnt_reg - CW'(1);
                    fcnt_next  = fcnt_reg + CW'(1);
                    n_next     = n_reg + NW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= teq_pkg::ST_INIT;
            time_reg  <= '0;
            id_reg    <= 32'd1;
            qhead_reg <= '0;
            fhead_reg <= '0;
            qcnt_reg  <= '0;
            fcnt_reg  <= CW'(SLOTS);
            init_reg  <= '0;
            ov_reg    <= 1'b0;
            ofin_reg  <= 1'b0;
            ol_reg    <= 1'b0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            time_reg  <= time_next;
            id_reg    <= id_next;
            qhead_reg <= qhead_next;
            fhead_reg <= fhead_next;
            fcnt_reg  <= fcnt_next;
            qcnt_reg  <= qcnt_next;
            init_reg  <= init_next;
            ov_reg    <= ov_next;
            ofin_reg  <= ofin_next;
            ol_reg    <= ol_next;
            n_reg     <= n_next;
            pend_reg  <= (state_reg == teq_pkg::ST_IDLE) && (state_next == teq_pkg::ST_SCHED_RD);
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        cur_reg <= cur_next;
        rem_reg <= rem_next;
        due_reg <= due_next;
        od_reg  <= od_next;
    end

    `include "timed_event_queue_assert.svh"
    `TEQ_ASSERT_IMP(a_count_sum, clk, rst_n, state_reg == teq_pkg::ST_IDLE,
        (qcnt_reg + fcnt_reg) == CW'(SLOTS))
    `TEQ_ASSERT_NEXT(a_out_hold, clk, rst_n, o_valid && !o_ready,
        o_valid && o_data == $past(o_data) && o_last == $past(o_last))
    `TEQ_ASSERT_NEXT(a_sched_seq, clk, rst_n, pend_reg,
        state_reg == teq_pkg::ST_SCHED_CMP)
endmodule

>>> rtl/timed_event_queue.sv
// Timed event queue: a pool of EVENT_SLOTS slots held in on-chip memory, linked
// in due-time order with equal due times kept in arrival order. The kind of each
// input transaction travels in s_tuser. After reset a clearing pass over every
// slot builds the free chain; no transaction is taken meanwhile. Advance, unused
// kinds and a schedule into a full pool finish in the idle state. A schedule
// writes the new slot, takes the next free slot and compares against the head,
// then reads and compares each queued event behind the head that the sorted
// walk compares against. A dispatch reads, checks and emits the head in turn,
// and stops on an empty queue, on the 64-event cap or on an event not yet due;
// it also waits while the receiver still holds the previous event. Each emitted
// event is held until the next one is found due or the dispatch ends, so last
// marks the final event of a dispatch; a dispatch with nothing due emits nothing.
// The final event may still wait on the output while the next input transaction
// is taken.
module timed_event_queue #(
    parameter int EVENT_SLOTS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // delay[31:0], event_type[39:32], event_source[71:40],
    // event_param[103:72], parent[135:104], advance_us[167:136]
    input  logic [167:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_event_id[31:0], out_parent_id[63:32], due_time_us[127:64],
    // out_type[135:128], out_source[167:136], out_param[199:168]
    output logic [199:0] m_tdata,
    output logic         m_tlast
);
    localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

    teq_pkg::slot_data_t pay, wdata, rdata, od;
    logic                data_we, link_we;
    logic [AW-1:0]       data_waddr, data_raddr, link_waddr, link_wdata, link_raddr;
    logic [AW-1:0]       link_rdata;

    always_comb
    begin
        pay.due    = '0;
        pay.id     = '0;
        pay.etype  = s_tdata[39:32];
        pay.source = s_tdata[71:40];
        pay.param  = s_tdata[103:72];
        pay.parent = s_tdata[135:104];
    end

    assign m_tdata = {od.param, od.source, od.etype, od.due, od.parent, od.id};

    teq_ctrl #(.SLOTS(EVENT_SLOTS), .AW(AW)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_kind(s_tuser), .in_delay(s_tdata[31:0]),
        .in_advance(s_tdata[167:136]), .in_payload(pay),
        .o_valid(m_tvalid), .o_ready(m_tready), .o_data(od), .o_last(m_tlast),
        .data_we(data_we), .data_waddr(data_waddr), .data_wdata(wdata),
        .data_raddr(data_raddr), .data_rdata(rdata),
        .link_we(link_we), .link_waddr(link_waddr), .link_wdata(link_wdata),
        .link_raddr(link_raddr), .link_rdata(link_rdata)
    );

    teq_mem #(.SLOTS(EVENT_SLOTS), .AW(AW)) u_mem (
        .clk(clk),
        .data_we(data_we), .data_waddr(data_waddr), .data_wdata(wdata),
        .data_raddr(data_raddr), .data_rdata(rdata),
        .link_we(link_we), .link_waddr(link_waddr), .link_wdata(link_wdata),
        .link_raddr(link_raddr), .link_rdata(link_rdata)
    );
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    localparam int SLOTS = 64;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] parent;
        logic [63:0] due;
        logic [7:0]  etype;
        logic [31:0] source;
        logic [31:0] param;
        logic        last;
    } event_out_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] delay;
        logic [7:0]  etype;
        logic [31:0] source;
        logic [31:0] param;
        logic [31:0] parent;
        logic [31:0] adv;
        int          n_typed;
        logic [31:0] typed_id;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic         m_tlast;

    timed_event_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Scheduler copy: pending events kept as a due-ordered list.
    logic [63:0] now_us;
    logic [31:0] id_counter;
    event_out_t  pending[$];
    event_out_t  due_events[$];
    int          errors;
    int          typed_count;
    logic [31:0] typed_first_id;
    bit          typed_active;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic predict(input logic [1:0] kind, input logic [31:0] delay,
                           input logic [7:0] etype, input logic [31:0] source,
                           input logic [31:0] param, input logic [31:0] parent,
                           input logic [31:0] adv);
        event_out_t e;
        int pos;
        int n;
        if (kind == teq_pkg::KIND_SCHEDULE)
        begin
            if (pending.size() < SLOTS)
            begin
                e.id = id_counter;
                e.parent = parent;
                e.due = now_us + {32'd0, delay};
                e.etype = etype;
                e.source = source;
                e.param = param;
                e.last = 1'b0;
                id_counter = id_counter + 32'd1;
                pos = pending.size();
                for (int i = 0; i < pending.size(); i++)
                begin
                    if (pending[i].due > e.due)
                    begin
                        pos = i;
                        break;
                    end
                end
                pending.insert(pos, e);
            end
        end
        else if (kind == teq_pkg::KIND_ADVANCE)
            now_us = now_us + {32'd0, adv};
        else if (kind == teq_pkg::KIND_DISPATCH)
        begin
            n = 0;
            while (pending.size() > 0 && n < teq_pkg::MAX_RESULTS && pending[0].due <= now_us)
            begin
                e = pending.pop_front();
                due_events.push_back(e);
                n++;
            end
            if (n > 0)
                due_events[due_events.size() - 1].last = 1'b1;
        end
    endtask

    // Output checker; receiver stalls on its own LFSR pattern.
    logic [15:0] stall_lfsr;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_lfsr <= 16'hACE1;
        end
        else
        begin
            stall_lfsr <= {stall_lfsr[14:0],
                           stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
            m_tready <= (stall_lfsr[7:5] != 3'd0) || stall_lfsr[15];
            if (m_tvalid && m_tready)
            begin
                event_out_t got;
                event_out_t want;
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[127:64], m_tdata[135:128],
                       m_tdata[167:136], m_tdata[199:168], m_tlast};
                if (due_events.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = due_events.pop_front();
                    if (typed_active && typed_count > 0)
                    begin
                        if (got.id !== typed_first_id)
                        begin
                            $display("%0t: typed id expected %h actual %h", $time,
                                     typed_first_id, got.id);
                            errors++;
                        end
                        typed_first_id = typed_first_id + 32'd1;
                        typed_count--;
                    end
                    if (got.id !== want.id)
                    begin
                        $display("%0t: event id expected %h actual %h", $time, want.id, got.id);
                        errors++;
                    end
                    if (got.parent !== want.parent)
                    begin
                        $display("%0t: parent expected %h actual %h", $time,
                                 want.parent, got.parent);
                        errors++;
                    end
                    if (got.due !== want.due)
                    begin
                        $display("%0t: due time expected %h actual %h", $time, want.due, got.due);
                        errors++;
                    end
                    if (got.etype !== want.etype)
                    begin
                        $display("%0t: type expected %h actual %h", $time, want.etype, got.etype);
                        errors++;
                    end
                    if (got.source !== want.source)
                    begin
                        $display("%0t: source expected %h actual %h", $time,
                                 want.source, got.source);
                        errors++;
                    end
                    if (got.param !== want.param)
                    begin
                        $display("%0t: param expected %h actual %h", $time, want.param, got.param);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    int burst_left;

    // Sends one transaction; gaps come between bursts.
    task automatic send(input logic [1:0] kind, input logic [31:0] delay,
                        input logic [7:0] etype, input logic [31:0] source,
                        input logic [31:0] param, input logic [31:0] parent,
                        input logic [31:0] adv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {adv, parent, param, source, etype, delay};
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict(kind, delay, etype, source, param, parent, adv);
    endtask

    task automatic send_random_schedule(input logic [31:0] delay);
        send(teq_pkg::KIND_SCHEDULE, delay, 8'($urandom), $urandom, $urandom, $urandom,
             $urandom);
    endtask

    stim_row_t rows[$];

    task automatic add_row(input logic [1:0] kind, input logic [31:0] delay,
                           input logic [31:0] adv, input int n_typed,
                           input logic [31:0] typed_id);
        stim_row_t r;
        r.kind = kind;
        r.delay = delay;
        r.etype = 8'($urandom);
        r.source = $urandom;
        r.param = $urandom;
        r.parent = $urandom;
        r.adv = adv;
        r.n_typed = n_typed;
        r.typed_id = typed_id;
        rows.push_back(r);
    endtask

    int wait_cycles;

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        now_us = '0;
        id_counter = 32'd1;
        errors = 0;
        burst_left = 0;
        typed_active = 1'b0;
        typed_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: dispatch on empty, extremes, equal-time ordering,
        // largest delay, unused kind. Ids after reset start at 1.
        add_row(teq_pkg::KIND_DISPATCH, 32'd0, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_SCHEDULE, 32'd0, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_SCHEDULE, 32'd0, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_DISPATCH, 32'd0, 32'd0, 2, 32'd1);
        add_row(teq_pkg::KIND_SCHEDULE, 32'hFFFF_FFFF, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_SCHEDULE, 32'd5, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_SCHEDULE, 32'd5, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_SCHEDULE, 32'd2, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0);
        add_row(teq_pkg::KIND_DISPATCH, 32'd0, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_ADVANCE, 32'd0, 32'd4, 0, 32'd0);
        add_row(teq_pkg::KIND_DISPATCH, 32'd0, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_ADVANCE, 32'd0, 32'd1, 0, 32'd0);
        add_row(teq_pkg::KIND_DISPATCH, 32'd0, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_ADVANCE, 32'd0, 32'hFFFF_FFFF, 0, 32'd0);
        add_row(teq_pkg::KIND_DISPATCH, 32'd0, 32'd0, 0, 32'd0);
        add_row(teq_pkg::KIND_ADVANCE, 32'd0, 32'd0, 0, 32'd0);
        foreach (rows[i])
        begin
            if (rows[i].n_typed > 0)
            begin
                typed_active = 1'b1;
                typed_count = rows[i].n_typed;
                typed_first_id = rows[i].typed_id;
            end
            send(rows[i].kind, rows[i].delay, rows[i].etype, rows[i].source,
                 rows[i].param, rows[i].parent, rows[i].adv);
        end

        // Fill the pool past full, then one dispatch drains exactly the cap.
        for (int i = 0; i < SLOTS + 3; i++)
            send_random_schedule($urandom_range(0, 3));
        send(teq_pkg::KIND_ADVANCE, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd3);
        send(teq_pkg::KIND_DISPATCH, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0);

        // Random part: mostly schedules with small delays, advances, dispatches.
        for (int i = 0; i < 42; i++)
        begin
            int pick;
            pick = $urandom_range(0, 19);
            if (pick < 10)
                send_random_schedule(($urandom_range(0, 9) == 0) ? $urandom
                                                                  : $urandom_range(0, 40));
            else if (pick < 14)
                send(teq_pkg::KIND_ADVANCE, $urandom, 8'($urandom), $urandom, $urandom,
                     $urandom,
                     ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 30));
            else if (pick < 19)
                send(teq_pkg::KIND_DISPATCH, $urandom, 8'($urandom), $urandom, $urandom,
                     $urandom, $urandom);
            else
                send(teq_pkg::KIND_UNUSED, $urandom, 8'($urandom), $urandom, $urandom,
                     $urandom, $urandom);
        end
        send(teq_pkg::KIND_ADVANCE, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send(teq_pkg::KIND_DISPATCH, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (due_events.size() > 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && due_events.size() == 0)
            $display("PASS timed_event_queue");
        else
            $display("FAIL timed_event_queue");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL timed_event_queue");
        $finish;
    end
endmodule
